[sv/gmptw_pkg.sv]
// Shared types and constants for the grid max path sum unit.
package gmptw_pkg;

    localparam int COIN_W    = 32;
    localparam int WALL_W    = 12;
    localparam int TOTAL_W   = 48;
    localparam int BEST_W    = 47;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

    typedef logic signed [COIN_W-1:0]  coin_t;
    typedef logic        [WALL_W-1:0]  wall_t;
    typedef logic signed [TOTAL_W-1:0] total_t;
    typedef logic        [BEST_W-1:0]  best_t;
    typedef logic        [CFG_W-1:0]   cfg_data_t;

    // one entry of the row buffer or the left neighbor
    typedef struct packed {
        logic   valid;
        total_t total;
    } slot_t;

    // result of the walk cell handed to the best cell
    typedef struct packed {
        logic   reach;
        total_t total;
        logic   last;
    } cell_res_t;

endpackage

[sv/gmptw_walk_cell.sv]
// Walk cell: grid position, row buffer, left neighbor and per-cell total.
module gmptw_walk_cell #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gmptw_pkg::cfg_data_t  num_rows,
    input  gmptw_pkg::cfg_data_t  num_cols,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  gmptw_pkg::coin_t      coin_value,
    input  logic                  has_wall,
    input  gmptw_pkg::wall_t      wall_step,
    output logic                  res_valid,
    input  logic                  res_stall,
    output gmptw_pkg::cell_res_t  res
);
    import gmptw_pkg::*;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int POS_W = ((ROW_W > COL_W) ? ROW_W : COL_W) + 1;
    localparam int ARR_W = (POS_W > WALL_W) ? POS_W : WALL_W;
    localparam int RCNT_W = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
    localparam int CCNT_W = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;

    logic [ROW_W-1:0]  row_index_reg;
    logic [ROW_W-1:0]  row_index_next;
    logic [COL_W-1:0]  col_index_reg;
    logic [COL_W-1:0]  col_index_next;
    slot_t             left_reg;
    slot_t             left_next;
    slot_t             up_rd_reg;
    slot_t             up_rd_next;
    slot_t             line_mem [MAX_COLS];
    logic              res_valid_reg;
    logic              res_valid_next;
    cell_res_t         res_reg;

    logic [RCNT_W-1:0] rows_ext;
    logic [RCNT_W-1:0] rows_eff;
    logic [CCNT_W-1:0] cols_ext;
    logic [CCNT_W-1:0] cols_eff;
    logic              accept;
    logic              start;
    logic [ARR_W-1:0]  arrival;
    logic              blocked;
    logic              up_ok;
    logic              left_ok;
    logic              pick_left;
    total_t            base_total;
    total_t            coin_ext;
    logic              reach;
    total_t            total;
    logic              row_end;
    logic              last;

    // size registers: zero acts as one, oversize clamps to the maximum
    always_comb
    begin
        rows_ext = RCNT_W'(num_rows);
        cols_ext = CCNT_W'(num_cols);
        if (rows_ext == '0)
            rows_eff = RCNT_W'(1);
        else if (rows_ext > RCNT_W'(MAX_ROWS))
            rows_eff = RCNT_W'(MAX_ROWS);
        else
            rows_eff = rows_ext;
        if (cols_ext == '0)
            cols_eff = CCNT_W'(1);
        else if (cols_ext > CCNT_W'(MAX_COLS))
            cols_eff = CCNT_W'(MAX_COLS);
        else
            cols_eff = cols_ext;
    end

    assign in_stall = res_valid_reg && res_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        start     = (row_index_reg == '0) && (col_index_reg == '0);
        arrival   = ARR_W'(row_index_reg) + ARR_W'(col_index_reg);
        blocked   = has_wall && (arrival >= ARR_W'(wall_step));
        up_ok     = (row_index_reg != '0) && up_rd_reg.valid;
        left_ok   = (col_index_reg != '0) && left_reg.valid;
        pick_left = left_ok && (!up_ok || (left_reg.total > up_rd_reg.total));
        base_total = pick_left ? left_reg.total : up_rd_reg.total;
        coin_ext  = total_t'(coin_value);
        if (start)
        begin
            reach = 1'b1;
            total = coin_ext;
        end
        else if (!blocked && (up_ok || left_ok))
        begin
            reach = 1'b1;
            total = base_total + coin_ext;
        end
        else
        begin
            reach = 1'b0;
            total = '0;
        end
        row_end = (CCNT_W'(col_index_reg) + CCNT_W'(1)) >= cols_eff;
        last    = row_end && ((RCNT_W'(row_index_reg) + RCNT_W'(1)) >= rows_eff);
    end

    always_comb
    begin
        row_index_next = row_index_reg;
        col_index_next = col_index_reg;
        left_next      = left_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (accept)
        begin
            res_valid_next = 1'b1;
            if (last)
            begin
                row_index_next = '0;
                col_index_next = '0;
                left_next      = '0;
            end
            else if (row_end)
            begin
                row_index_next = row_index_reg + ROW_W'(1);
                col_index_next = '0;
                left_next      = '0;
            end
            else
            begin
                col_index_next  = col_index_reg + COL_W'(1);
                left_next.valid = reach;
                left_next.total = total;
            end
        end
    end

    // row buffer read follows the next column; same-column write is forwarded
    always_comb
    begin
        if (accept && (col_index_next == col_index_reg))
        begin
            up_rd_next.valid = reach;
            up_rd_next.total = total;
        end
        else
            up_rd_next = line_mem[col_index_next];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_index_reg] <= '{valid: reach, total: total};
        end
        up_rd_reg <= up_rd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg <= '0;
            col_index_reg <= '0;
            left_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            row_index_reg <= row_index_next;
            col_index_reg <= col_index_next;
            left_reg      <= left_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= '{reach: reach, total: total, last: last};
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[sv/gmptw_best_cell.sv]
// Best cell: running best over reachable cells and the output register.
module gmptw_best_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    output logic                  res_stall,
    input  gmptw_pkg::cell_res_t  res,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  cell_reachable,
    output gmptw_pkg::total_t     cell_total,
    output gmptw_pkg::best_t      best_total,
    output logic                  last_cell
);
    import gmptw_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    best_t     run_best_reg;
    best_t     run_best_next;
    logic      reach_reg;
    total_t    total_reg;
    best_t     best_reg;
    logic      last_reg;
    logic      load;
    logic      better;
    best_t     new_best;

    assign res_stall = out_valid_reg && out_stall;
    assign load      = res_valid && !res_stall;

    always_comb
    begin
        better   = res.reach && (res.total > $signed({1'b0, run_best_reg}));
        new_best = better ? res.total[BEST_W-1:0] : run_best_reg;
        run_best_next  = run_best_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            run_best_next  = res.last ? '0 : new_best;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            run_best_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            run_best_reg  <= run_best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            reach_reg <= res.reach;
            total_reg <= res.total;
            best_reg  <= new_best;
            last_reg  <= res.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cell_reachable = reach_reg;
    assign cell_total     = total_reg;
    assign best_total     = best_reg;
    assign last_cell      = last_reg;

endmodule

[sv/grid_max_path_sum_with_timed_walls_unit.sv]
// Top level of the grid max path sum unit with timed walls.
// Takes one grid cell per request in row-major order and returns one result per
// cell. Sustained rate is one request per cycle with no bubbles while the output
// is not held; a held walk result stalls the input. A result passes two register
// stages, the walk result register and the best cell output register. The rate is
// set by the left-neighbor loop (compare, select, 48-bit add) and the row buffer,
// a MAX_COLS-deep memory with one write and one registered read per cycle whose
// read address tracks the next column. The running best is kept one cell later.
// The row buffer needs no clearing after reset: row 0 never reads it.
module grid_max_path_sum_with_timed_walls_unit #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [gmptw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  gmptw_pkg::cfg_data_t  cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  gmptw_pkg::coin_t      coin_value,
    input  logic                  has_wall,
    input  gmptw_pkg::wall_t      wall_step,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  cell_reachable,
    output gmptw_pkg::total_t     cell_total,
    output gmptw_pkg::best_t      best_total,
    output logic                  last_cell
);
    import gmptw_pkg::*;

    cfg_data_t  num_rows_reg;
    cfg_data_t  num_rows_next;
    cfg_data_t  num_cols_reg;
    cfg_data_t  num_cols_next;
    logic       res_valid;
    logic       res_stall;
    cell_res_t  res;

    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_NUM_ROWS: num_rows_next = cfg_data;
                REG_NUM_COLS: num_cols_next = cfg_data;
                default:      num_rows_next = num_rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CFG_W'(1);
            num_cols_reg <= CFG_W'(1);
        end
        else
        begin
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
        end
    end

    gmptw_walk_cell #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .num_rows   (num_rows_reg),
        .num_cols   (num_cols_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .coin_value (coin_value),
        .has_wall   (has_wall),
        .wall_step  (wall_step),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    gmptw_best_cell u_best (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res            (res),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_reachable (cell_reachable),
        .cell_total     (cell_total),
        .best_total     (best_total),
        .last_cell      (last_cell)
    );

    // unreachable cells report a zero total
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cell_reachable |-> cell_total == '0)
        else $error("unreachable cell with nonzero total");

    // running best covers every nonnegative reachable total
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cell_reachable && !cell_total[TOTAL_W-1]
            |-> best_total >= cell_total[BEST_W-1:0])
        else $error("running best below reachable total");

    // a held walk result keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("walk result changed while held");

    // input back-pressure only when the walk stage is full and held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> res_valid && out_valid && out_stall)
        else $error("input stalled without a full pipeline");

endmodule

[tb/sv/gmptw_cell_checker.sv]
`timescale 1ns / 1ps
// Checker for the grid max path sum unit: predicts each cell result and compares it.
module gmptw_cell_checker #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gmptw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  gmptw_pkg::cfg_data_t             cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  gmptw_pkg::coin_t                 coin_value,
    input  logic                             has_wall,
    input  gmptw_pkg::wall_t                 wall_step,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             cell_reachable,
    input  gmptw_pkg::total_t                cell_total,
    input  gmptw_pkg::best_t                 best_total,
    input  logic                             last_cell,
    output int                               fail_count,
    output int                               pending
);
    import gmptw_pkg::*;

    typedef struct packed {
        logic   reach;
        total_t total;
        best_t  best;
        logic   last;
    } cell_result_t;

    cell_result_t expected_cells[$];

    slot_t       row_above [MAX_COLS];
    slot_t       left_cell;
    int unsigned walk_row;
    int unsigned walk_col;
    longint      best_sum;
    cfg_data_t   rows_reg;
    cfg_data_t   cols_reg;

    function automatic int unsigned dim_of(input cfg_data_t v, input int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function automatic void predict_cell(input coin_t coins, input logic walled,
                                         input wall_t wall_at);
        int unsigned  rows;
        int unsigned  cols;
        int unsigned  slot;
        longint       add;
        longint       pick;
        longint       sum;
        logic         up_ok;
        logic         left_ok;
        logic         reach;
        logic         row_end;
        logic         last;
        cell_result_t res;
        rows = dim_of(rows_reg, MAX_ROWS);
        cols = dim_of(cols_reg, MAX_COLS);
        slot = (walk_col < MAX_COLS) ? walk_col : MAX_COLS - 1;
        add = coins;
        reach = 1'b0;
        sum = 0;
        if (walk_row == 0 && walk_col == 0)
        begin
            reach = 1'b1;
            sum = add;
        end
        else if (!(walled && (walk_row + walk_col) >= wall_at))
        begin
            up_ok = (walk_row > 0) && row_above[slot].valid;
            left_ok = (walk_col > 0) && left_cell.valid;
            pick = 0;
            if (up_ok)
                pick = $signed(row_above[slot].total);
            if (left_ok && (!up_ok || $signed(left_cell.total) > pick))
                pick = $signed(left_cell.total);
            if (up_ok || left_ok)
            begin
                reach = 1'b1;
                sum = pick + add;
            end
        end
        if (reach && sum > best_sum)
            best_sum = sum;
        row_above[slot].valid = reach;
        row_above[slot].total = sum[TOTAL_W-1:0];
        left_cell = row_above[slot];
        row_end = (walk_col + 1 >= cols);
        last = row_end && (walk_row + 1 >= rows);
        res.reach = reach;
        res.total = sum[TOTAL_W-1:0];
        res.best = best_sum[BEST_W-1:0];
        res.last = last;
        expected_cells.push_back(res);
        if (last)
        begin
            walk_row = 0;
            walk_col = 0;
            left_cell = '0;
            best_sum = 0;
        end
        else if (row_end)
        begin
            walk_col = 0;
            walk_row++;
            left_cell = '0;
        end
        else
            walk_col++;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        cell_result_t want;
        if (expected_cells.size() == 0)
        begin
            $error("result with no cell pending: cell_total 0x%0h", cell_total);
            fail_count++;
        end
        else
        begin
            want = expected_cells.pop_front();
            check_field("cell_reachable", want.reach, cell_reachable);
            check_field("cell_total", {16'b0, want.total}, {16'b0, cell_total});
            check_field("best_total", want.best, best_total);
            check_field("last_cell", want.last, last_cell);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (row_above[i])
                row_above[i] = '0;
            left_cell = '0;
            walk_row = 0;
            walk_col = 0;
            best_sum = 0;
            rows_reg = cfg_data_t'(1);
            cols_reg = cfg_data_t'(1);
            expected_cells.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_NUM_ROWS: rows_reg = cfg_data;
                    REG_NUM_COLS: cols_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_cell(coin_value, has_wall, wall_step);
            pending = expected_cells.size();
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top of the testbench for the grid max path sum unit: stimulus, idling and verdict.
module tb;
    import gmptw_pkg::*;

    localparam int          MAX_DIM      = 1024;
    localparam int unsigned RANDOM_CELLS = 1250;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          QUIET_LIMIT  = 5000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    cfg_data_t             cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    coin_t                 coin_value;
    logic                  has_wall;
    wall_t                 wall_step;
    logic                  out_valid;
    logic                  out_stall;
    logic                  cell_reachable;
    total_t                cell_total;
    best_t                 best_total;
    logic                  last_cell;
    int                    fail_count;
    int                    pending;

    int unsigned rows_eff;
    int unsigned cols_eff;
    int unsigned pos_row;
    int unsigned pos_col;
    int unsigned written_cols;
    int unsigned random_sent;
    int          idle_pct;
    int          stall_pct;
    bit          hold_ask;
    bit          hold_taken;
    int          quiet_cycles = 0;

    grid_max_path_sum_with_timed_walls_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .coin_value     (coin_value),
        .has_wall       (has_wall),
        .wall_step      (wall_step),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_reachable (cell_reachable),
        .cell_total     (cell_total),
        .best_total     (best_total),
        .last_cell      (last_cell)
    );

    gmptw_cell_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .coin_value     (coin_value),
        .has_wall       (has_wall),
        .wall_step      (wall_step),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_reachable (cell_reachable),
        .cell_total     (cell_total),
        .best_total     (best_total),
        .last_cell      (last_cell),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        hold_taken = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_ask && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    function automatic int unsigned dim_of(input cfg_data_t v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_data_t v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_NUM_ROWS)
            rows_eff = dim_of(v);
        else
            cols_eff = dim_of(v);
    endtask

    task automatic set_grid(input cfg_data_t r, input cfg_data_t c);
        wait_idle();
        write_reg(REG_NUM_ROWS, r);
        write_reg(REG_NUM_COLS, c);
    endtask

    task automatic send_cell(input coin_t c, input logic w, input wall_t t);
        bit taken;
        @(negedge clk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        coin_value <= c;
        has_wall <= w;
        wall_step <= t;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !in_stall;
        end
        // track walk position for wall times and safe resizing
        if (pos_col + 1 > written_cols)
            written_cols = pos_col + 1;
        if (pos_col + 1 >= cols_eff)
        begin
            if (pos_row + 1 >= rows_eff)
                pos_row = 0;
            else
                pos_row++;
            pos_col = 0;
        end
        else
            pos_col++;
    endtask

    task automatic random_cell();
        int unsigned arrival;
        int          t;
        coin_t       c;
        logic        w;
        arrival = pos_row + pos_col;
        case ($urandom_range(7))
            0: c = coin_t'(32'h7FFF_FFFF);
            1: c = coin_t'(32'h8000_0000);
            2, 3: c = coin_t'($urandom);
            default: c = coin_t'(int'($urandom_range(200)) - 100);
        endcase
        w = ($urandom_range(9) < 4);
        case ($urandom_range(3))
            0, 1: t = int'(arrival) + int'($urandom_range(3)) - 1;
            2: t = $urandom_range(4095);
            default: t = $urandom_range(arrival);
        endcase
        if (t < 0)
            t = 0;
        if (t > 4095)
            t = 4095;
        send_cell(c, w, wall_t'(t));
    endtask

    task automatic run_grid(input cfg_data_t r, input cfg_data_t c, input bit fresh);
        cfg_data_t v;
        if (fresh)
            set_grid(r, c);
        do
        begin
            // occasional resize in the middle of a grid
            if ((pos_row != 0 || pos_col != 0) && $urandom_range(39) == 0)
            begin
                wait_idle();
                v = cfg_data_t'($urandom_range(1, 8));
                if ($urandom_range(1) == 0)
                    write_reg(REG_NUM_ROWS, v);
                else
                begin
                    if (pos_row != 0 && dim_of(v) > written_cols)
                        v = cfg_data_t'(written_cols);
                    write_reg(REG_NUM_COLS, v);
                end
            end
            random_cell();
            random_sent++;
        end
        while (pos_row != 0 || pos_col != 0);
    endtask

    initial
    begin
        cfg_data_t   r;
        cfg_data_t   c;
        int unsigned phase;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_NUM_ROWS;
        cfg_data = '0;
        in_valid = 1'b0;
        coin_value = '0;
        has_wall = 1'b0;
        wall_step = '0;
        rows_eff = 1;
        cols_eff = 1;
        pos_row = 0;
        pos_col = 0;
        written_cols = 0;
        random_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_ask = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 1x1 grids from reset size; start cell ignores its wall
        send_cell(coin_t'(32'h7FFF_FFFF), 1'b1, wall_t'(0));
        send_cell(coin_t'(32'h8000_0000), 1'b0, wall_t'(4095));
        // zero sizes act as one
        set_grid(cfg_data_t'(0), cfg_data_t'(0));
        send_cell(coin_t'(5), 1'b1, wall_t'(4095));

        // 3x3: walls at and after arrival; cut-off paths
        set_grid(cfg_data_t'(3), cfg_data_t'(3));
        send_cell(coin_t'(10), 1'b1, wall_t'(0));
        send_cell(coin_t'(5), 1'b1, wall_t'(1));
        send_cell(coin_t'(7), 1'b0, wall_t'(0));
        send_cell(coin_t'(32'h7FFF_FFFF), 1'b1, wall_t'(2));
        send_cell(coin_t'(-3), 1'b1, wall_t'(4095));
        send_cell(coin_t'(1), 1'b0, wall_t'(4095));
        send_cell(coin_t'(32'h8000_0000), 1'b0, wall_t'(0));
        send_cell(coin_t'(0), 1'b1, wall_t'(3));
        send_cell(coin_t'(-1), 1'b1, wall_t'(5));

        // oversize registers clamp; shrink mid-grid ends the row, then the grid
        set_grid(cfg_data_t'(2047), cfg_data_t'(2047));
        repeat (4) random_cell();
        wait_idle();
        write_reg(REG_NUM_COLS, cfg_data_t'(2));
        repeat (2) random_cell();
        wait_idle();
        write_reg(REG_NUM_ROWS, cfg_data_t'(1024));
        write_reg(REG_NUM_ROWS, cfg_data_t'(1));
        random_cell();

        // long receiver hold-off while the sender keeps pushing
        hold_ask = 1'b1;
        run_grid(cfg_data_t'(10), cfg_data_t'(10), 1'b1);

        while (random_sent < RANDOM_CELLS)
        begin
            phase = random_sent * 4 / RANDOM_CELLS;
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 88;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 88;
                end
                default:
                begin
                    idle_pct = 35;
                    stall_pct = 35;
                end
            endcase
            if ($urandom_range(9) == 0)
            begin
                r = cfg_data_t'($urandom_range(12, 40));
                c = cfg_data_t'($urandom_range(1, 3));
            end
            else if ($urandom_range(9) == 0)
            begin
                r = cfg_data_t'($urandom_range(1, 3));
                c = cfg_data_t'($urandom_range(12, 40));
            end
            else
            begin
                r = cfg_data_t'($urandom_range(1, 6));
                c = cfg_data_t'($urandom_range(1, 6));
            end
            if ($urandom_range(15) == 0)
                r = '0;
            if ($urandom_range(15) == 0)
                c = '0;
            run_grid(r, c, $urandom_range(2) != 0);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
